@@ design/scps_pkg.sv @@
// Shared types and constants for the polynomial sine / root cosine block.
// No dependencies; imported by scps_isqrt and sine_cosine_poly_sqrt.
package scps_pkg;

    localparam logic [15:0] ANGLE_MAX = 16'd51472;

    localparam logic signed [31:0] C3_RESET = -32'sd178956971;
    localparam logic signed [31:0] C5_RESET = 32'sd8947849;
    localparam logic signed [31:0] C7_RESET = -32'sd213043;
    localparam logic signed [31:0] C9_RESET = 32'sd2959;

    localparam logic [7:0] REG_C3 = 8'd0;
    localparam logic [7:0] REG_C5 = 8'd1;
    localparam logic [7:0] REG_C7 = 8'd2;
    localparam logic [7:0] REG_C9 = 8'd3;

    // Square root: 50-bit radicand, 25 result bits, two bits per stage (one in the last).
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int REM_W   = 27;
    localparam int SQ_STEP = 2;
    localparam int SQ_NS   = (ROOT_W + SQ_STEP - 1) / SQ_STEP;

    // Fields that ride along with the root through the pipeline.
    typedef struct packed {
        logic signed [15:0] sine;
        logic               neg;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sq;

endpackage

@@ design/scps_isqrt.sv @@
// Pipelined integer square root, two result bits per register stage (one in the last).
// Depends on scps_pkg for the word formats.
module scps_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [scps_pkg::RAD_W-1:0]  i_rad,
    input  scps_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [scps_pkg::ROOT_W-1:0] o_root,
    output scps_pkg::t_side             o_side
);
    import scps_pkg::*;

    t_sq   r_st [SQ_NS];
    t_side r_sd [SQ_NS];
    logic [SQ_NS-1:0] r_v;
    logic [SQ_NS:0]   w_en;

    function automatic t_sq sq_steps(t_sq s, int base);
        t_sq              o;
        logic [REM_W+1:0] remw;
        logic [REM_W+1:0] trial;
        o = s;
        for (int j = 0; j < SQ_STEP; j++) begin
            if (base + j < ROOT_W) begin
                remw  = {o.rem, o.rad[RAD_W-1 -: 2]};
                trial = (REM_W+2)'({o.root, 2'b01});
                o.rad = {o.rad[RAD_W-3:0], 2'b00};
                if (remw >= trial) begin
                    o.rem  = REM_W'(remw - trial);
                    o.root = {o.root[ROOT_W-2:0], 1'b1};
                end else begin
                    o.rem  = REM_W'(remw);
                    o.root = {o.root[ROOT_W-2:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    assign w_en[SQ_NS] = i_ready;
    assign o_ready     = w_en[0];

    genvar k;
    generate
        for (k = 0; k < SQ_NS; k++) begin : g_stage
            t_sq   w_in;
            t_side w_sd;
            logic  w_vi;
            assign w_en[k] = !r_v[k] || w_en[k+1];
            if (k == 0) begin : g_first
                assign w_in = '{rem: '0, root: '0, rad: i_rad};
                assign w_sd = i_side;
                assign w_vi = i_valid;
            end else begin : g_next
                assign w_in = r_st[k-1];
                assign w_sd = r_sd[k-1];
                assign w_vi = r_v[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_v[k] <= w_vi;
                end
                if (w_en[k]) begin
                    r_st[k] <= sq_steps(w_in, k * SQ_STEP);
                    r_sd[k] <= w_sd;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[SQ_NS-1];
    assign o_root  = r_st[SQ_NS-1].root;
    assign o_side  = r_sd[SQ_NS-1];

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_root <= ROOT_W'(25'd16777216))
        else $error("root above one");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> o_ready)
        else $error("empty root pipeline refused a word");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("stalled root word dropped");

endmodule

@@ design/sine_cosine_poly_sqrt.sv @@
// Top level: polynomial sine and square-root cosine, fully pipelined.
// Depends on scps_pkg and scps_isqrt.
//
// Input channel (i_in_valid / o_in_ready) carries one angle word: unsigned
// Q1.15 radians plus a flag that negates the cosine. Angles above pi/2 are
// clamped to pi/2. Output channel (o_out_valid / i_out_ready) carries one
// result word: sine and cosine, signed Q2.14.
// Sine is t + c3 t^3 + c5 t^5 + c7 t^7 + c9 t^9 with the coefficients
// (signed Q1.30) in four registers written through i_cfg_we / i_cfg_idx /
// i_cfg_data; indexes beyond the fourth are ignored. Write them only while
// the pipe is empty.
// Throughput: one word per cycle while the output is not stalled. The
// pipe has 25 register stages: 11 polynomial / radicand stages, 13
// square root stages (two root bits each, one in the last) and the
// output register.
// Each stage advances when it is empty or the next one advances, so a
// stalled receiver freezes only the occupied tail; bubbles are squeezed
// out and the input keeps taking words until the pipe is full.
// Reset (synchronous, active low) empties the pipe and restores the
// default Taylor coefficients.
module sine_cosine_poly_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_angle,
    input  logic               i_negate_cos,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_cosine,
    output logic signed [15:0] o_sine,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import scps_pkg::*;

    localparam int NST = 11;

    // Round a Q.54 product half away from zero to Q.24.
    function automatic logic signed [33:0] rnd30(logic signed [62:0] m);
        logic signed [62:0] tmp;
        tmp = m + 63'sd536870912 - 63'($unsigned(m[62]));
        return 34'(tmp >>> 30);
    endfunction

    // Coefficient registers
    logic signed [31:0] r_c3, r_c5, r_c7, r_c9;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3 <= C3_RESET;
            r_c5 <= C5_RESET;
            r_c7 <= C7_RESET;
            r_c9 <= C9_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_C3:  r_c3 <= i_cfg_data;
                REG_C5:  r_c5 <= i_cfg_data;
                REG_C7:  r_c7 <= i_cfg_data;
                REG_C9:  r_c9 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids and advance chain
    logic [NST:1] r_v;
    logic [NST+1:1] w_en;
    logic           w_sq_ready;
    logic           w_sq_valid;
    logic [ROOT_W-1:0] w_root;
    t_side          w_sq_side;
    t_side          w_sq_in;
    logic           r_vo;
    logic           w_en_o;

    assign w_en_o        = !r_vo || i_out_ready;
    assign w_en[NST+1]   = w_sq_ready;
    assign o_in_ready    = w_en[1];

    genvar k;
    generate
        for (k = 1; k <= NST; k++) begin : g_v
            assign w_en[k] = !r_v[k] || w_en[k+1];
            if (k == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (w_en[k]) begin
                        r_v[k] <= i_in_valid;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (w_en[k]) begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    endgenerate

    // Pipeline payload
    logic [15:0]        r1_a;
    logic [NST:1]       r_neg;
    logic [24:0]        r2_t, r3_t, r4_t;
    logic [25:0]        r2_u, r3_u, r4_u, r5_u;
    logic [25:0]        r3_p3;
    logic [27:0]        r4_p5;
    logic [28:0]        r5_p7;
    logic [29:0]        r6_p9;
    logic signed [62:0] r4_m3, r5_m5, r6_m7, r7_m9;
    logic signed [35:0] r5_s, r6_s, r7_s, r8_s;
    logic signed [15:0] r9_sin, r10_sin, r11_sin;
    logic [23:0]        r9_mag;
    logic               r9_big, r10_big;
    logic [47:0]        r10_sq;
    logic [RAD_W-1:0]   r11_rad;

    logic signed [25:0] w_sr;
    logic signed [35:0] w_sabs;

    always_comb begin
        w_sr   = 26'((r8_s + 36'sd512 - 36'($unsigned(r8_s[35]))) >>> 10);
        w_sabs = r8_s[35] ? -r8_s : r8_s;
    end

    always_ff @(posedge i_clk) begin
        // clamp the angle
        if (w_en[1]) begin
            r1_a     <= (i_angle > ANGLE_MAX) ? ANGLE_MAX : i_angle;
            r_neg[1] <= i_negate_cos;
        end
        // t in Q.24, u = t^2 rounded to Q.24
        if (w_en[2]) begin
            r2_t <= {r1_a, 9'd0};
            r2_u <= 26'((33'(r1_a) * 33'(r1_a) + 33'd32) >> 6);
        end
        if (w_en[3]) begin
            r3_t  <= r2_t;
            r3_u  <= r2_u;
            r3_p3 <= 26'((52'(r2_t) * 52'(r2_u) + 52'd8388608) >> 24);
        end
        if (w_en[4]) begin
            r4_t  <= r3_t;
            r4_u  <= r3_u;
            r4_p5 <= 28'((54'(r3_p3) * 54'(r3_u) + 54'd8388608) >> 24);
            r4_m3 <= 63'(r_c3) * $signed(63'(r3_p3));
        end
        if (w_en[5]) begin
            r5_u  <= r4_u;
            r5_p7 <= 29'((55'(r4_p5) * 55'(r4_u) + 55'd8388608) >> 24);
            r5_m5 <= 63'(r_c5) * $signed(63'(r4_p5));
            r5_s  <= $signed(36'(r4_t)) + 36'(rnd30(r4_m3));
        end
        if (w_en[6]) begin
            r6_p9 <= 30'((56'(r5_p7) * 56'(r5_u) + 56'd8388608) >> 24);
            r6_m7 <= 63'(r_c7) * $signed(63'(r5_p7));
            r6_s  <= r5_s + 36'(rnd30(r5_m5));
        end
        if (w_en[7]) begin
            r7_m9 <= 63'(r_c9) * $signed(63'(r6_p9));
            r7_s  <= r6_s + 36'(rnd30(r6_m7));
        end
        if (w_en[8]) begin
            r8_s <= r7_s + 36'(rnd30(r7_m9));
        end
        // sine to Q.14 with saturation, |s| for the radicand
        if (w_en[9]) begin
            if (w_sr > 26'sd32767)        r9_sin <= 16'sd32767;
            else if (w_sr < -26'sd32768)  r9_sin <= -16'sd32768;
            else                          r9_sin <= 16'(w_sr);
            r9_big <= (w_sabs >= 36'sd16777216);
            r9_mag <= w_sabs[23:0];
        end
        if (w_en[10]) begin
            r10_sin <= r9_sin;
            r10_big <= r9_big;
            r10_sq  <= 48'(r9_mag) * 48'(r9_mag);
        end
        // radicand 1 - s^2 in Q.48, clamp at zero
        if (w_en[11]) begin
            r11_sin <= r10_sin;
            r11_rad <= r10_big ? '0 : (RAD_W'(50'd281474976710656) - RAD_W'(r10_sq));
        end
    end

    generate
        for (k = 2; k <= NST; k++) begin : g_neg
            always_ff @(posedge i_clk) begin
                if (w_en[k]) r_neg[k] <= r_neg[k-1];
            end
        end
    endgenerate

    assign w_sq_in = t_side'{sine: r11_sin, neg: r_neg[NST]};

    scps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NST]),
        .o_ready (w_sq_ready),
        .i_rad   (r11_rad),
        .i_side  (w_sq_in),
        .o_valid (w_sq_valid),
        .i_ready (w_en_o),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Output register: round root to Q.14, apply the flag
    logic [15:0] w_cmag;
    assign w_cmag = 16'((26'(w_root) + 26'd512) >> 10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en_o) begin
            r_vo <= w_sq_valid;
        end
        if (w_en_o) begin
            o_sine   <= w_sq_side.sine;
            o_cosine <= w_sq_side.neg ? -$signed(w_cmag) : $signed(w_cmag);
        end
    end

    assign o_out_valid = r_vo;

    a_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_sine > 16'sd16384 || o_sine < -16'sd16384))
            |-> o_cosine == 16'sd0)
        else $error("cosine nonzero with sine beyond one");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cosine <= 16'sd16384 && o_cosine >= -16'sd16384))
        else $error("cosine beyond one");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused while output empty");

endmodule
